[design/sorted_timeout_list_top_macros.svh]
// assertion macros for the sorted timeout list
`ifndef SORTED_TIMEOUT_LIST_TOP_MACROS_SVH
`define SORTED_TIMEOUT_LIST_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define STL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/stl_pkg.sv]
// shared types and constants for the sorted timeout list
`default_nettype none
package stl_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int DL_W = 32;
  localparam logic [DL_W-1:0] NO_DEADLINE = '1;

  localparam logic CMD_ARM    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIRST,
    ST_WALK,
    ST_TAIL,
    ST_CHEAD,
    ST_CHDL,
    ST_CWALK,
    ST_CLINK
  } state_t;

  typedef struct packed {
    logic dl_we;
    logic ln_we;
  } mem_we_t;

endpackage
`default_nettype wire

[design/stl_store.sv]
// slot store: deadline and link memories sharing one read address
`default_nettype none
module stl_store #(
  parameter int SLOTS = stl_pkg::SLOTS_DEF,
  localparam int IdW = $clog2(SLOTS),
  localparam int LinkW = $clog2(SLOTS + 1)
) (
  input  wire                         clk,
  input  stl_pkg::mem_we_t            we,
  input  wire  [IdW-1:0]              dl_waddr,
  input  wire  [stl_pkg::DL_W-1:0]    dl_wdata,
  input  wire  [IdW-1:0]              ln_waddr,
  input  wire  [LinkW-1:0]            ln_wdata,
  input  wire  [IdW-1:0]              raddr,
  output logic [stl_pkg::DL_W-1:0]    dl_rdata,
  output logic [LinkW-1:0]            ln_rdata
);
  import stl_pkg::*;

  logic [DL_W-1:0]  dl_mem [SLOTS];
  logic [LinkW-1:0] ln_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we.dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    dl_rdata <= dl_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.ln_we) begin
      ln_mem[ln_waddr] <= ln_wdata;
    end
    ln_rdata <= ln_mem[raddr];
  end

endmodule
`default_nettype wire

[design/sorted_timeout_list_top.sv]
// sorted timeout list: timer slots linked in deadline order, arm and cancel commands
// Each command is taken with start while busy is low and answers with one word on
// out_valid for a single cycle; the receiver cannot stall, so sample it then.
// Commands run one at a time and walk the list one slot per cycle through the
// single read port of the slot store. An arm that lands at the head answers straight
// from the execute state; otherwise it walks to its place and links the new slot in.
// A cancel of the head takes the deadline of the slot after it as the new earliest
// one; otherwise it walks to the slot ahead of the cancelled one and relinks past it.
// busy drops in the cycle the result word is shown. No clearing pass after reset.
`default_nettype none
module sorted_timeout_list_top #(
  parameter int SLOTS = stl_pkg::SLOTS_DEF,
  localparam int IdW = $clog2(SLOTS),
  localparam int LinkW = $clog2(SLOTS + 1)
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire                       in_cmd,
  input  wire  [IdW-1:0]            in_timer_id,
  input  wire  [stl_pkg::DL_W-1:0]  in_delay_ticks,
  input  wire  [stl_pkg::DL_W-1:0]  in_now_ticks,
  output logic                      out_valid,
  output logic                      out_done_res,
  output logic [stl_pkg::DL_W-1:0]  out_earliest_deadline,
  output logic [LinkW-1:0]          out_head_slot
);
  import stl_pkg::*;

  `include "sorted_timeout_list_top_macros.svh"

  localparam logic [LinkW-1:0] LIST_END = LinkW'(SLOTS);

  state_t             state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [IdW-1:0]     id_r, id_nxt;
  logic [DL_W-1:0]    when_r, when_nxt;
  logic [LinkW-1:0]   head_r, head_nxt;
  logic [DL_W-1:0]    head_dl_r, head_dl_nxt;
  logic [IdW-1:0]     prev_r, prev_nxt;
  logic [LinkW-1:0]   cur_r, cur_nxt;
  logic [SLOTS-1:0]   run_r, run_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               done_r, done_nxt;

  mem_we_t            mem_we;
  logic [IdW-1:0]     ln_waddr;
  logic [LinkW-1:0]   ln_wdata;
  logic [IdW-1:0]     raddr;
  logic [DL_W-1:0]    dl_rdata;
  logic [LinkW-1:0]   ln_rdata;

  logic id_ok, do_arm, do_cancel, arm_at_head, ln_end, walk_on, hit_head, hit_link;

  stl_store #(.SLOTS(SLOTS)) u_store (
    .clk      (clk),
    .we       (mem_we),
    .dl_waddr (id_r),
    .dl_wdata (when_r),
    .ln_waddr (ln_waddr),
    .ln_wdata (ln_wdata),
    .raddr    (raddr),
    .dl_rdata (dl_rdata),
    .ln_rdata (ln_rdata)
  );

  assign id_ok       = LinkW'(id_r) < LIST_END;
  assign do_arm      = id_ok && (cmd_r == CMD_ARM) && !run_r[id_r];
  assign do_cancel   = id_ok && (cmd_r == CMD_CANCEL) && run_r[id_r];
  assign arm_at_head = (head_r == LIST_END) || (when_r <= head_dl_r);
  assign ln_end      = ln_rdata == LIST_END;
  assign walk_on     = when_r > dl_rdata;
  assign hit_head    = head_r == LinkW'(id_r);
  assign hit_link    = ln_rdata == LinkW'(id_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (do_arm) begin
          state_nxt = arm_at_head ? ST_IDLE : ST_FIRST;
        end else if (do_cancel) begin
          state_nxt = hit_head ? ST_CHEAD : ST_CWALK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIRST: state_nxt = ln_end ? ST_TAIL : ST_WALK;
      ST_WALK: begin
        if (walk_on && !ln_end) state_nxt = ST_WALK;
        else state_nxt = ST_TAIL;
      end
      ST_TAIL:  state_nxt = ST_IDLE;
      ST_CHEAD: state_nxt = ln_end ? ST_IDLE : ST_CHDL;
      ST_CHDL:  state_nxt = ST_IDLE;
      ST_CWALK: begin
        priority if (hit_link) state_nxt = ST_CLINK;
        else if (ln_end) state_nxt = ST_IDLE;
        else state_nxt = ST_CWALK;
      end
      ST_CLINK: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    when_nxt      = when_r;
    head_nxt      = head_r;
    head_dl_nxt   = head_dl_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    run_nxt       = run_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    mem_we        = '0;
    ln_waddr      = id_r;
    ln_wdata      = head_r;
    raddr         = head_r[IdW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = in_cmd;
          id_nxt   = in_timer_id;
          when_nxt = in_delay_ticks + in_now_ticks;
        end
      end
      ST_EXEC: begin
        done_nxt = do_arm || do_cancel;
        if (do_arm) begin
          run_nxt[id_r] = 1'b1;
          mem_we.dl_we  = 1'b1;
          if (arm_at_head) begin
            mem_we.ln_we  = 1'b1;
            head_nxt      = LinkW'(id_r);
            head_dl_nxt   = when_r;
            out_valid_nxt = 1'b1;
          end else begin
            prev_nxt = head_r[IdW-1:0];
          end
        end else if (do_cancel) begin
          run_nxt[id_r] = 1'b0;
          if (hit_head) begin
            raddr = id_r;
          end else begin
            prev_nxt = head_r[IdW-1:0];
          end
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      ST_FIRST: begin
        // ln_rdata is the slot after the head
        if (ln_end) begin
          mem_we.ln_we = 1'b1;
          ln_waddr     = prev_r;
          ln_wdata     = LinkW'(id_r);
          cur_nxt      = LIST_END;
        end else begin
          cur_nxt = ln_rdata;
          raddr   = ln_rdata[IdW-1:0];
        end
      end
      ST_WALK: begin
        if (walk_on) begin
          prev_nxt = cur_r[IdW-1:0];
          if (ln_end) begin
            mem_we.ln_we = 1'b1;
            ln_waddr     = cur_r[IdW-1:0];
            ln_wdata     = LinkW'(id_r);
            cur_nxt      = LIST_END;
          end else begin
            cur_nxt = ln_rdata;
            raddr   = ln_rdata[IdW-1:0];
          end
        end else begin
          // new slot goes in front of cur
          mem_we.ln_we = 1'b1;
          ln_waddr     = prev_r;
          ln_wdata     = LinkW'(id_r);
        end
      end
      ST_TAIL: begin
        mem_we.ln_we  = 1'b1;
        ln_waddr      = id_r;
        ln_wdata      = cur_r;
        out_valid_nxt = 1'b1;
      end
      ST_CHEAD: begin
        head_nxt = ln_rdata;
        if (ln_end) begin
          head_dl_nxt   = NO_DEADLINE;
          out_valid_nxt = 1'b1;
        end else begin
          raddr = ln_rdata[IdW-1:0];
        end
      end
      ST_CHDL: begin
        head_dl_nxt   = dl_rdata;
        out_valid_nxt = 1'b1;
      end
      ST_CWALK: begin
        // ln_rdata is the successor of prev
        priority if (hit_link) begin
          raddr = id_r;
        end else if (ln_end) begin
          out_valid_nxt = 1'b1;
        end else begin
          prev_nxt = ln_rdata[IdW-1:0];
          raddr    = ln_rdata[IdW-1:0];
        end
      end
      ST_CLINK: begin
        mem_we.ln_we  = 1'b1;
        ln_waddr      = prev_r;
        ln_wdata      = ln_rdata;
        out_valid_nxt = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= LIST_END;
      head_dl_r   <= NO_DEADLINE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      head_dl_r   <= head_dl_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    id_r   <= id_nxt;
    when_r <= when_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    done_r <= done_nxt;
  end

  assign busy                  = state_r != ST_IDLE;
  assign out_valid             = out_valid_r;
  assign out_done_res          = done_r;
  assign out_earliest_deadline = head_dl_r;
  assign out_head_slot         = head_r;

  `STL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `STL_ASSERT_NOW(a_empty_dl, head_r == LIST_END, head_dl_r == NO_DEADLINE, "empty list deadline")
  `STL_ASSERT_NOW(a_result_after_work, out_valid, $past(busy) && !busy, "result word without work")

endmodule
`default_nettype wire
